FILE: rtl/q8dp_pkg.sv
// q8dp_pkg: shared types, constants and float helpers for the q8_0 block dot product
package q8dp_pkg;

  localparam int LANES      = 4;
  localparam int LANE_ELEMS = 8;
  localparam int LANE_W     = 19;
  localparam int DOT_W      = 21;
  localparam int WIDE_W     = 51;
  localparam int FP_LAT     = 3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [7:0]  DOT_EXPO  = 8'd150;

  // unpacked binary32 operand: value = man * 2^(expo - 150)
  typedef struct packed {
    logic        sign;
    logic [7:0]  expo;
    logic [23:0] man;
    logic        zero;
    logic        inf;
    logic        nan;
  } fp_unp_t;

  function automatic fp_unp_t unpack_f32(logic [31:0] b);
    fp_unp_t u;
    u.sign = b[31];
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.zero = (b[30:23] == 8'h00) && (b[22:0] == 23'd0);
    u.man  = {(b[30:23] != 8'h00), b[22:0]};
    u.expo = (b[30:23] == 8'h00) ? 8'd1 : b[30:23];
    return u;
  endfunction

  function automatic fp_unp_t unpack_f16(logic [15:0] h);
    fp_unp_t u;
    u.sign = h[15];
    u.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    u.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    u.zero = (h[14:10] == 5'h00) && (h[9:0] == 10'd0);
    u.man  = {13'd0, (h[14:10] != 5'h00), h[9:0]};
    u.expo = (h[14:10] == 5'h00) ? 8'd126 : ({3'd0, h[14:10]} + 8'd125);
    return u;
  endfunction

  function automatic fp_unp_t unpack_dot(logic signed [DOT_W-1:0] d);
    fp_unp_t u;
    logic [DOT_W-1:0] mag;
    mag    = d[DOT_W-1] ? (~d + 1'b1) : d;
    u.sign = d[DOT_W-1];
    u.nan  = 1'b0;
    u.inf  = 1'b0;
    u.zero = (d == '0);
    u.man  = {3'd0, mag};
    u.expo = DOT_EXPO;
    return u;
  endfunction

  function automatic logic [5:0] lead_pos(logic [WIDE_W-1:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < WIDE_W; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // pn has its leading one at the top bit, e is the biased exponent of that bit
  function automatic logic [31:0] round_pack(logic sign, logic signed [10:0] e,
                                             logic [WIDE_W-1:0] pn);
    logic [WIDE_W-1:0] sft;
    logic [5:0]        shv;
    logic              stk;
    logic [7:0]        ef;
    logic [23:0]       m;
    logic              rb;
    logic              sb;
    logic [30:0]       packed_v;
    sft = pn;
    stk = 1'b0;
    ef  = e[7:0];
    shv = 6'd0;
    if (e < 11'sd1) begin
      if (e < -11'sd49) shv = 6'd51;
      else shv = 6'(11'sd1 - e);
      sft = pn >> shv;
      stk = |(pn & ~({WIDE_W{1'b1}} << shv));
      ef  = 8'd0;
    end
    m  = sft[WIDE_W-1:WIDE_W-24];
    rb = sft[WIDE_W-25];
    sb = (|sft[WIDE_W-26:0]) | stk;
    packed_v = {ef, m[22:0]} + 31'(rb & (sb | m[0]));
    if (e >= 11'sd255) return {sign, 8'hFF, 23'd0};
    return {sign, packed_v};
  endfunction

endpackage

FILE: rtl/q8dp_lane.sv
// q8dp_lane: eight signed byte products summed into one registered lane total
module q8dp_lane (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic [63:0]                          weights,
  input  logic [63:0]                          acts,
  output logic signed [q8dp_pkg::LANE_W-1:0]   lane_sum
);

  logic signed [q8dp_pkg::LANE_W-1:0] sum_next;

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < q8dp_pkg::LANE_ELEMS; k++) begin
      sum_next = sum_next + q8dp_pkg::LANE_W'($signed(weights[8*k +: 8]) *
                                             $signed(acts[8*k +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (load) lane_sum <= sum_next;
  end

endmodule

FILE: rtl/q8dp_merge.sv
// q8dp_merge: adds the lane totals into the block's integer dot product
module q8dp_merge (
  input  logic                                clk,
  input  logic signed [q8dp_pkg::LANE_W-1:0]  lane_sums [q8dp_pkg::LANES],
  output logic signed [q8dp_pkg::DOT_W-1:0]   dot
);

  logic signed [q8dp_pkg::DOT_W-1:0] dot_next;

  always_comb begin
    dot_next = '0;
    for (int l = 0; l < q8dp_pkg::LANES; l++) begin
      dot_next = dot_next + q8dp_pkg::DOT_W'(lane_sums[l]);
    end
  end

  always_ff @(posedge clk) begin
    dot <= dot_next;
  end

endmodule

FILE: rtl/q8dp_fmul.sv
// q8dp_fmul: three-stage binary32 multiplier with round to nearest even
module q8dp_fmul (
  input  logic                clk,
  input  q8dp_pkg::fp_unp_t   a,
  input  q8dp_pkg::fp_unp_t   b,
  output logic [31:0]         prod
);

  logic        s1_nan, s1_inf, s1_zero, s1_sign;
  logic [47:0] s1_p;
  logic [9:0]  s1_esum;

  logic        s2_nan, s2_inf, s2_zero, s2_sign;
  logic [q8dp_pkg::WIDE_W-1:0] s2_pn;
  logic signed [10:0]          s2_e;

  logic [q8dp_pkg::WIDE_W-1:0] wide;
  logic [5:0]                  lpos;

  always_ff @(posedge clk) begin
    s1_nan  <= a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
    s1_inf  <= a.inf | b.inf;
    s1_zero <= a.zero | b.zero;
    s1_sign <= a.sign ^ b.sign;
    s1_p    <= a.man * b.man;
    s1_esum <= {2'd0, a.expo} + {2'd0, b.expo};
  end

  assign wide = {s1_p, 3'd0};
  assign lpos = q8dp_pkg::lead_pos(wide);

  always_ff @(posedge clk) begin
    s2_nan  <= s1_nan;
    s2_inf  <= s1_inf;
    s2_zero <= s1_zero;
    s2_sign <= s1_sign;
    s2_pn   <= wide << (6'd50 - lpos);
    s2_e    <= $signed({5'd0, lpos}) + $signed({1'b0, s1_esum}) - 11'sd176;
  end

  always_ff @(posedge clk) begin
    if (s2_nan) prod <= q8dp_pkg::CANON_NAN;
    else if (s2_inf) prod <= {s2_sign, 8'hFF, 23'd0};
    else if (s2_zero) prod <= {s2_sign, 31'd0};
    else prod <= q8dp_pkg::round_pack(s2_sign, s2_e, s2_pn);
  end

endmodule

FILE: rtl/q8dp_fadd.sv
// q8dp_fadd: three-stage binary32 adder with round to nearest even
module q8dp_fadd (
  input  logic         clk,
  input  logic [31:0]  a_bits,
  input  logic [31:0]  b_bits,
  output logic [31:0]  sum
);

  q8dp_pkg::fp_unp_t a, b, big, lit;
  logic [31:0]       big_bits;
  logic              swap;
  logic [7:0]        d;
  logic [5:0]        dv;
  logic [q8dp_pkg::WIDE_W-1:0] big_ext, lit_ext, lit_al;
  logic              spec;
  logic [31:0]       spec_bits;

  logic        s1_spec, s1_sign;
  logic [31:0] s1_spec_bits;
  logic [q8dp_pkg::WIDE_W-1:0] s1_s;
  logic [7:0]  s1_e;

  logic        s2_spec, s2_sign, s2_zero;
  logic [31:0] s2_spec_bits;
  logic [q8dp_pkg::WIDE_W-1:0] s2_pn;
  logic signed [10:0]          s2_e;
  logic [5:0]  lpos;

  always_comb begin
    a    = q8dp_pkg::unpack_f32(a_bits);
    b    = q8dp_pkg::unpack_f32(b_bits);
    swap = {b.expo, b.man} > {a.expo, a.man};
    big  = swap ? b : a;
    lit  = swap ? a : b;
    big_bits = swap ? b_bits : a_bits;
    d    = big.expo - lit.expo;
    dv   = (d > 8'd50) ? 6'd51 : 6'(d);
    big_ext = {1'b0, big.man, 26'd0};
    lit_ext = {1'b0, lit.man, 26'd0};
    lit_al  = (lit_ext >> dv);
    lit_al[0] = lit_al[0] | (|(lit_ext & ~({q8dp_pkg::WIDE_W{1'b1}} << dv)));
    spec      = 1'b1;
    spec_bits = big_bits;
    if (a.nan || b.nan || (a.inf && b.inf && (a.sign != b.sign))) begin
      spec_bits = q8dp_pkg::CANON_NAN;
    end else if (a.inf) begin
      spec_bits = {a.sign, 8'hFF, 23'd0};
    end else if (b.inf) begin
      spec_bits = {b.sign, 8'hFF, 23'd0};
    end else if (a.zero && b.zero) begin
      spec_bits = {a.sign & b.sign, 31'd0};
    end else if (lit.zero) begin
      spec_bits = big_bits;
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_spec      <= spec;
    s1_spec_bits <= spec_bits;
    s1_sign      <= big.sign;
    s1_e         <= big.expo;
    s1_s         <= (big.sign == lit.sign) ? (big_ext + lit_al) : (big_ext - lit_al);
  end

  assign lpos = q8dp_pkg::lead_pos(s1_s);

  always_ff @(posedge clk) begin
    s2_spec      <= s1_spec;
    s2_spec_bits <= s1_spec_bits;
    s2_sign      <= s1_sign;
    s2_zero      <= (s1_s == '0);
    s2_pn        <= s1_s << (6'd50 - lpos);
    s2_e         <= $signed({5'd0, lpos}) + $signed({3'd0, s1_e}) - 11'sd49;
  end

  always_ff @(posedge clk) begin
    if (s2_spec) sum <= s2_spec_bits;
    else if (s2_zero) sum <= 32'd0;
    else sum <= q8dp_pkg::round_pack(s2_sign, s2_e, s2_pn);
  end

endmodule

FILE: rtl/q8_0_block_dot_product_top.sv
// q8_0_block_dot_product_top: q8_0 block dot product with binary32 row accumulation
// One block pair is taken per beat; blk_stall then stays high until the block is idle
// again, so it takes no new block while busy: four byte lanes and the lane merge form
// the integer dot product, one three-stage float multiplier is used twice (weight scale
// times activation scale, then times the dot product) and a three-stage float adder
// folds the term into the row sum; each pass waits out that unit's latency.
// A block marked last_block emits the row sum as one result beat and clears the sum.
// The result sits in an output register, so a pending result does not hold up input
// unless the next last block finishes while it is still waiting.
module q8_0_block_dot_product_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         blk_valid,
  output logic         blk_stall,
  input  logic [15:0]  weight_scale,
  input  logic [31:0]  act_scale,
  input  logic [63:0]  weights_0_7,
  input  logic [63:0]  weights_8_15,
  input  logic [63:0]  weights_16_23,
  input  logic [63:0]  weights_24_31,
  input  logic [63:0]  acts_0_7,
  input  logic [63:0]  acts_8_15,
  input  logic [63:0]  acts_16_23,
  input  logic [63:0]  acts_24_31,
  input  logic         last_block,
  output logic         res_valid,
  input  logic         res_stall,
  output logic [31:0]  row_result
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCALE = 4'b0010,
    ST_TERM  = 4'b0100,
    ST_ADD   = 4'b1000
  } state_t;

  state_t      state, state_next;
  logic [1:0]  cnt;
  logic        accept;
  logic        done;
  logic        out_free;

  q8dp_pkg::fp_unp_t dw_unp;
  logic [31:0] dx_bits;
  logic        last;
  logic [31:0] scale_bits;
  logic [31:0] term_bits;
  logic [31:0] row_sum;

  logic [63:0] lane_w [q8dp_pkg::LANES];
  logic [63:0] lane_a [q8dp_pkg::LANES];
  logic signed [q8dp_pkg::LANE_W-1:0] lane_sums [q8dp_pkg::LANES];
  logic signed [q8dp_pkg::DOT_W-1:0]  dot;

  q8dp_pkg::fp_unp_t mul_a, mul_b;
  logic [31:0] mul_out;
  logic [31:0] add_out;

  assign blk_stall = (state != ST_IDLE);
  assign accept    = blk_valid && !blk_stall;
  assign done      = (cnt == 2'(q8dp_pkg::FP_LAT));
  assign out_free  = !res_valid || !res_stall;

  assign lane_w[0] = weights_0_7;
  assign lane_w[1] = weights_8_15;
  assign lane_w[2] = weights_16_23;
  assign lane_w[3] = weights_24_31;
  assign lane_a[0] = acts_0_7;
  assign lane_a[1] = acts_8_15;
  assign lane_a[2] = acts_16_23;
  assign lane_a[3] = acts_24_31;

  for (genvar l = 0; l < q8dp_pkg::LANES; l++) begin : g_lane
    q8dp_lane u_lane (
      .clk      (clk),
      .load     (accept),
      .weights  (lane_w[l]),
      .acts     (lane_a[l]),
      .lane_sum (lane_sums[l])
    );
  end

  q8dp_merge u_merge (
    .clk       (clk),
    .lane_sums (lane_sums),
    .dot       (dot)
  );

  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = dw_unp;
      mul_b = q8dp_pkg::unpack_f32(dx_bits);
    end else begin
      mul_a = q8dp_pkg::unpack_f32(scale_bits);
      mul_b = q8dp_pkg::unpack_dot(dot);
    end
  end

  q8dp_fmul u_fmul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_out)
  );

  q8dp_fadd u_fadd (
    .clk    (clk),
    .a_bits (row_sum),
    .b_bits (term_bits),
    .sum    (add_out)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SCALE;
      ST_SCALE: if (done) state_next = ST_TERM;
      ST_TERM:  if (done) state_next = ST_ADD;
      ST_ADD:   if (done && (!last || out_free)) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= 2'd0;
      row_sum   <= 32'd0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= 2'd0;
      else if (!done) cnt <= cnt + 2'd1;
      if (state == ST_ADD && state_next == ST_IDLE) begin
        row_sum <= last ? 32'd0 : add_out;
      end
      if (state == ST_ADD && state_next == ST_IDLE && last) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dw_unp  <= q8dp_pkg::unpack_f16(weight_scale);
      dx_bits <= act_scale;
      last    <= last_block;
    end
    if (state == ST_SCALE && done) scale_bits <= mul_out;
    if (state == ST_TERM && done) term_bits <= mul_out;
    if (state == ST_ADD && state_next == ST_IDLE && last) row_result <= add_out;
  end

endmodule

FILE: dv/q8dp_row_checker.sv
// q8dp_row_checker: predicts row sums from accepted block beats and checks result beats
module q8dp_row_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        blk_valid,
  input  logic        blk_stall,
  input  logic [15:0] weight_scale,
  input  logic [31:0] act_scale,
  input  logic [63:0] weights_0_7,
  input  logic [63:0] weights_8_15,
  input  logic [63:0] weights_16_23,
  input  logic [63:0] weights_24_31,
  input  logic [63:0] acts_0_7,
  input  logic [63:0] acts_8_15,
  input  logic [63:0] acts_16_23,
  input  logic [63:0] acts_24_31,
  input  logic        last_block,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [31:0] row_result,
  output int          fails,
  output int          pending,
  output int          rows_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] row_acc;
  logic [31:0] row_sums_q[$];

  // round a double to binary32, nearest-even, nan made canonical
  function automatic logic [31:0] to_f32(real v);
    logic [63:0] d;
    logic [63:0] mm;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] halfw;
    logic [31:0] r;
    logic        rnd;
    int          fe;
    int          sh;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF)
      return (d[51:0] != 0) ? q8dp_pkg::CANON_NAN : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    fe = int'(d[62:52]) - 1023 + 127;
    if (fe >= 255) return {d[63], 31'h7F80_0000};
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 60) return {d[63], 31'd0};
    mm = {11'd0, 1'b1, d[51:0]};
    keep = mm >> sh;
    rem = mm & ((64'd1 << sh) - 64'd1);
    halfw = 64'd1 << (sh - 1);
    rnd = (rem > halfw) || ((rem == halfw) && keep[0]);
    if (fe >= 1) r = {1'b0, 8'(fe), keep[22:0]} + 32'(rnd);
    else r = keep[31:0] + 32'(rnd);
    r[31] = d[63];
    return r;
  endfunction

  function automatic real f32_value(logic [31:0] b);
    real v;
    if (b[30:23] == 8'hFF)
      return $bitstoreal((b[22:0] != 0) ? 64'h7FF8_0000_0000_0000 :
                         {b[31], 63'h7FF0_0000_0000_0000});
    if (b[30:23] == 8'd0) v = real'(b[22:0]) * 2.0 ** (-149);
    else v = real'({1'b1, b[22:0]}) * 2.0 ** (real'(int'(b[30:23]) - 150));
    return b[31] ? -v : v;
  endfunction

  function automatic logic [31:0] half_bits_f32(logic [15:0] h);
    logic [9:0] man;
    logic [7:0] e;
    if (h[14:10] == 5'd0) begin
      if (h[9:0] == 10'd0) return {h[15], 31'd0};
      man = h[9:0];
      e = 8'd113;
      while (!man[9]) begin
        man = man << 1;
        e = e - 8'd1;
      end
      man = man << 1;
      return {h[15], e - 8'd1, man, 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
    return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
  endfunction

  function automatic int block_dot(logic [255:0] w, logic [255:0] a);
    int s;
    s = 0;
    for (int i = 0; i < 32; i++)
      s += int'($signed(w[8*i +: 8])) * int'($signed(a[8*i +: 8]));
    return s;
  endfunction

  int mism;

  always @(posedge clk) begin
    logic [31:0] scl;
    logic [31:0] term;
    logic [31:0] want;
    if (rst) begin
      row_acc <= 32'd0;
      row_sums_q.delete();
      fails <= 0;
      mism = 0;
      rows_seen <= 0;
    end else begin
      if (blk_valid && !blk_stall) begin
        scl = to_f32(f32_value(half_bits_f32(weight_scale)) * f32_value(act_scale));
        term = to_f32(f32_value(scl) * real'(block_dot(
          {weights_24_31, weights_16_23, weights_8_15, weights_0_7},
          {acts_24_31, acts_16_23, acts_8_15, acts_0_7})));
        want = to_f32(f32_value(row_acc) + f32_value(term));
        if (last_block) begin
          row_sums_q.push_back(want);
          row_acc <= 32'd0;
        end else begin
          row_acc <= want;
        end
      end
      if (res_valid && !res_stall) begin
        rows_seen <= rows_seen + 1;
        if (row_sums_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result beat %h", row_result);
        end else begin
          want = row_sums_q.pop_front();
          if (row_result !== want) begin
            mism++;
            if (mism <= 10)
              $display("row_result mismatch: expected %h actual %h", want, row_result);
          end
        end
      end
      fails <= mism;
    end
  end

  assign pending = row_sums_q.size();
endmodule

FILE: dv/tb_q8_0_block_dot_product_top.sv
// tb_q8_0_block_dot_product_top: stimulus and verdict for the q8_0 block dot product
module tb_q8_0_block_dot_product_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        blk_valid;
  logic        blk_stall;
  logic [15:0] weight_scale;
  logic [31:0] act_scale;
  logic [63:0] weights_0_7, weights_8_15, weights_16_23, weights_24_31;
  logic [63:0] acts_0_7, acts_8_15, acts_16_23, acts_24_31;
  logic        last_block;
  logic        res_valid;
  logic        res_stall;
  logic [31:0] row_result;
  int          fails;
  int          pending;
  int          rows_seen;
  int          cycles = 0;
  int          blocks_sent;
  logic        quiet;

  q8_0_block_dot_product_top dut (.*);

  q8dp_row_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int n;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 18);
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  function automatic logic [63:0] rand_bytes(int mode);
    logic [63:0] v;
    v = {$urandom, $urandom};
    case (mode)
      0: v = {8{8'h80}};
      1: v = {8{8'h7F}};
      2: v = 64'd0;
      3: for (int i = 0; i < 8; i++) v[8*i +: 8] = 8'($urandom_range(0, 6)) - 8'd3;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 19))
      0: return {1'($urandom), 15'h7C00};
      1: return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
      2: return {1'($urandom), 5'h00, 10'($urandom)};
      3: return 16'($urandom);
      default: return {1'($urandom), 5'($urandom_range(5, 20)), 10'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] rand_single();
    case ($urandom_range(0, 19))
      0: return {1'($urandom), 31'h7F80_0000};
      1: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))};
      2: return {1'($urandom), 8'h00, 23'($urandom)};
      3: return $urandom;
      4: return {1'($urandom), 8'($urandom_range(1, 10)), 23'($urandom)};
      5: return {1'($urandom), 8'($urandom_range(240, 254)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_block(logic [15:0] ws, logic [31:0] as, logic [255:0] w,
                            logic [255:0] a, logic lb);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 18);
      blk_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    weight_scale <= ws;
    act_scale <= as;
    {weights_24_31, weights_16_23, weights_8_15, weights_0_7} <= w;
    {acts_24_31, acts_16_23, acts_8_15, acts_0_7} <= a;
    last_block <= lb;
    blk_valid <= 1'b1;
    do @(posedge clk); while (blk_stall);
    blocks_sent++;
  endtask

  task automatic send_rand(int mw, int ma, logic lb);
    send_block(rand_half(), rand_single(),
               {rand_bytes(mw), rand_bytes(mw), rand_bytes(mw), rand_bytes(mw)},
               {rand_bytes(ma), rand_bytes(ma), rand_bytes(ma), rand_bytes(ma)}, lb);
  endtask

  initial begin
    int len;
    quiet = 1'b0;
    blocks_sent = 0;
    rst = 1'b1;
    blk_valid = 1'b0;
    weight_scale = '0;
    act_scale = '0;
    {weights_0_7, weights_8_15, weights_16_23, weights_24_31} = '0;
    {acts_0_7, acts_8_15, acts_16_23, acts_24_31} = '0;
    last_block = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // extremes of the integer dot product
    send_block(16'h3C00, 32'h3F80_0000, {256{1'b0}} | {32{8'h80}}, {32{8'h80}}, 1'b1);
    send_block(16'h3C00, 32'h3F80_0000, {32{8'h80}}, {32{8'h7F}}, 1'b1);
    send_block(16'hBC00, 32'h3F80_0000, {32{8'h7F}}, {32{8'h7F}}, 1'b1);
    send_block(16'h3C00, 32'h3F80_0000, '0, '0, 1'b1);
    // signed zero handling
    send_block(16'h8000, 32'h3F80_0000, {32{8'h01}}, {32{8'h01}}, 1'b1);
    // overflow to infinity, then inf minus inf in one row
    send_block(16'h7BFF, 32'h7F7F_FFFF, {32{8'h7F}}, {32{8'h7F}}, 1'b1);
    send_block(16'h7BFF, 32'h7F7F_FFFF, {32{8'h7F}}, {32{8'h7F}}, 1'b0);
    send_block(16'hFBFF, 32'h7F7F_FFFF, {32{8'h7F}}, {32{8'h7F}}, 1'b1);
    // infinity times zero, nan scales
    send_block(16'h7C00, 32'h0000_0000, {32{8'h01}}, {32{8'h01}}, 1'b1);
    send_block(16'h7E01, 32'h3F80_0000, {32{8'h01}}, {32{8'h01}}, 1'b1);
    send_block(16'h3C00, 32'hFFFF_FFFF, {32{8'h01}}, {32{8'h01}}, 1'b0);
    send_block(16'h3C00, 32'h3F80_0000, {32{8'h01}}, {32{8'h01}}, 1'b1);
    // subnormal half, subnormal products
    send_block(16'h0001, 32'h3F80_0000, {32{8'h01}}, {32{8'h01}}, 1'b1);
    send_block(16'h83FF, 32'h0080_0000, {32{8'h01}}, {32{8'h02}}, 1'b1);
    send_block(16'h0001, 32'h0000_0001, {32{8'h7F}}, {32{8'h7F}}, 1'b1);
    send_block(16'h0400, 32'h0040_0000, {32{8'h80}}, {32{8'h01}}, 1'b1);
    // cancellation across a row
    send_block(16'h3C00, 32'h3F80_0000, {32{8'h05}}, {32{8'h03}}, 1'b0);
    send_block(16'hBC00, 32'h3F80_0000, {32{8'h05}}, {32{8'h03}}, 1'b1);
    send_block(16'h7BFF, 32'h3380_0000, {32{8'h01}}, {32{8'h01}}, 1'b0);
    send_block(16'h3C00, 32'h3F80_0000, {32{8'h01}}, {32{8'h01}}, 1'b1);

    while (blocks_sent < 1000) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        send_rand($urandom_range(0, 12), $urandom_range(0, 12), i == len - 1);
    end
    quiet = 1'b1;
    for (int i = 0; i < 50; i++) send_rand(9, 9, i % 3 == 2 || i == 49);
    blk_valid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d block beats across %0d rows, including special scales and",
             blocks_sent, rows_seen);
    $display("extreme dot products, with stalls and gaps on both channels");
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
